### src/iee_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the Ising energy evaluator.
package iee_pkg;

    localparam int DEF_NODES       = 16;
    localparam int DEF_WEIGHT_BITS = 16;

    localparam int INDEX_W  = 8;
    localparam int PARAM_W  = 16;
    localparam int SPIN_W   = 16;
    localparam int ENERGY_W = 24;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    localparam logic signed [ENERGY_W-1:0] ENERGY_MAX = 24'sh7FFFFF;
    localparam logic signed [ENERGY_W-1:0] ENERGY_MIN = 24'sh800000;

    // Control handed from the sequencer to the accumulator.
    typedef struct packed {
        logic clear;  // start a new sum
        logic add;    // read data carries a term this cycle
        logic pos;    // term sign product is +1, so it is subtracted
    } acc_ctrl_t;

    // Spin bit of a node; nodes past the spin field read as clear.
    function automatic logic node_spin(input logic [SPIN_W-1:0] bits,
                                       input logic [5:0] node);
        logic res;
        res = 1'b0;
        if (node < 6'(SPIN_W)) begin
            res = bits[node[3:0]];
        end
        return res;
    endfunction

endpackage

### src/iee_param_mem.sv
`timescale 1ns / 1ps
// Parameter table memory: one write port, one registered read port.
module iee_param_mem import iee_pkg::*; #(
    parameter int DEPTH  = 136,
    parameter int DATA_W = DEF_WEIGHT_BITS,
    parameter int ADDR_W = 8
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### src/iee_energy_acc.sv
`timescale 1ns / 1ps
// Signed accumulator of table terms with saturation to the energy width.
module iee_energy_acc import iee_pkg::*; #(
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS,
    parameter int ACC_W       = 25
) (
    input  logic                         aclk,
    input  acc_ctrl_t                    ctrl,
    input  logic signed [WEIGHT_BITS-1:0] weight,
    output logic signed [ENERGY_W-1:0]   energy
);

    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] term;
    logic [ACC_W-ENERGY_W:0] top_bits;

    always_comb begin
        term = ACC_W'(weight);
        acc_next = acc_reg;
        if (ctrl.clear) begin
            acc_next = '0;
        end else if (ctrl.add) begin
            // negated energy: subtract terms whose spin product is +1
            acc_next = ctrl.pos ? (acc_reg - term) : (acc_reg + term);
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
    end

    assign top_bits = acc_reg[ACC_W-1:ENERGY_W-1];

    always_comb begin
        if (top_bits == '0 || top_bits == '1) begin
            energy = acc_reg[ENERGY_W-1:0];
        end else if (acc_reg[ACC_W-1]) begin
            energy = ENERGY_MIN;
        end else begin
            energy = ENERGY_MAX;
        end
    end

endmodule

### src/ising_energy_evaluator_unit.sv
`timescale 1ns / 1ps
// Ising energy evaluator: the top level holds the sequencer and the output word register.
// After reset the block sweeps its parameter table to zero, one entry a cycle,
// with s_ready low. Then it takes one word at a time. A write word stores its
// parameter in the accept cycle, and its acknowledge passes through the result
// state into the output word register. An evaluate word reads the whole table
// through the single read port of the parameter memory, one entry a cycle, then
// passes through the drain and result states to the output register. The output
// register frees the input side: a new word is taken while the last result still
// waits for m_ready.
module ising_energy_evaluator_unit import iee_pkg::*; #(
    parameter int NODES       = DEF_NODES,
    parameter int WEIGHT_BITS = DEF_WEIGHT_BITS
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic                       s_cmd,
    input  logic [INDEX_W-1:0]         s_param_index,
    input  logic signed [PARAM_W-1:0]  s_param_value,
    input  logic [SPIN_W-1:0]          s_spin_bits,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [ENERGY_W-1:0] m_energy,
    output logic                       m_is_energy
);

    localparam int PAIR_COUNT = NODES * (NODES - 1) / 2;
    localparam int TABLE_SIZE = PAIR_COUNT + NODES;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int NODE_W     = $clog2(NODES);
    localparam int ACC_RAW    = WEIGHT_BITS + ADDR_W + 1;
    localparam int ACC_W      = (ACC_RAW > ENERGY_W + 1) ? ACC_RAW : ENERGY_W + 1;

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_SWEEP  = 3'd2;
    localparam logic [2:0] ST_DRAIN  = 3'd3;
    localparam logic [2:0] ST_RESULT = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [NODE_W-1:0] i_reg, i_next;
    logic [NODE_W-1:0] j_reg, j_next;
    logic              phase_reg, phase_next;   // 0: pair couplings, 1: local fields
    logic [SPIN_W-1:0] spin_reg;
    logic              is_energy_reg;
    logic              add_d_reg;
    logic              pos_d_reg;
    logic              term_pos;
    logic              si, sj;

    logic              m_valid_reg;
    logic signed [ENERGY_W-1:0] m_energy_reg;
    logic              m_is_energy_reg;

    logic              accept;
    logic              out_load;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [WEIGHT_BITS-1:0] mem_wdata;
    logic [WEIGHT_BITS-1:0] mem_rdata;
    acc_ctrl_t         acc_ctrl;
    logic signed [ENERGY_W-1:0] acc_energy;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == ST_RESULT) && (!m_valid_reg || m_ready);

    // table writes: zero during the clearing sweep, else an in-range write word
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = '0;
        if (state_reg == ST_CLEAR) begin
            mem_we = 1'b1;
        end else if (accept && s_cmd == CMD_WRITE &&
                     32'(s_param_index) < 32'(TABLE_SIZE)) begin
            mem_we    = 1'b1;
            mem_waddr = ADDR_W'(s_param_index);
            mem_wdata = WEIGHT_BITS'(s_param_value);
        end
    end

    assign si       = node_spin(spin_reg, 6'(i_reg));
    assign sj       = node_spin(spin_reg, 6'(j_reg));
    assign term_pos = phase_reg ? si : (si == sj);

    always_comb begin
        state_next = state_reg;
        addr_next  = addr_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_CLEAR: begin
                addr_next = addr_reg + ADDR_W'(1);
                if (addr_reg == ADDR_W'(TABLE_SIZE - 1)) begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                addr_next  = '0;
                i_next     = '0;
                j_next     = NODE_W'(1);
                phase_next = 1'b0;
                if (accept) begin
                    state_next = (s_cmd == CMD_EVAL) ? ST_SWEEP : ST_RESULT;
                end
            end
            ST_SWEEP: begin
                addr_next = addr_reg + ADDR_W'(1);
                if (!phase_reg) begin
                    if (j_reg == NODE_W'(NODES - 1)) begin
                        if (i_reg == NODE_W'(NODES - 2)) begin
                            phase_next = 1'b1;
                            i_next     = '0;
                        end else begin
                            i_next = i_reg + NODE_W'(1);
                            j_next = i_reg + NODE_W'(2);
                        end
                    end else begin
                        j_next = j_reg + NODE_W'(1);
                    end
                end else begin
                    i_next = i_reg + NODE_W'(1);
                end
                if (addr_reg == ADDR_W'(TABLE_SIZE - 1)) begin
                    addr_next  = '0;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            addr_reg    <= '0;
            add_d_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            addr_reg  <= addr_next;
            add_d_reg <= (state_reg == ST_SWEEP);
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        phase_reg <= phase_next;
        pos_d_reg <= term_pos;
        if (accept) begin
            spin_reg      <= s_spin_bits;
            is_energy_reg <= (s_cmd == CMD_EVAL);
        end
        if (out_load) begin
            m_energy_reg    <= is_energy_reg ? acc_energy : '0;
            m_is_energy_reg <= is_energy_reg;
        end
    end

    // term sign is delayed by a register, as the read data is, to meet it
    assign acc_ctrl.clear = accept && (s_cmd == CMD_EVAL);
    assign acc_ctrl.add   = add_d_reg;
    assign acc_ctrl.pos   = pos_d_reg;

    iee_param_mem #(
        .DEPTH  (TABLE_SIZE),
        .DATA_W (WEIGHT_BITS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (addr_reg),
        .rdata (mem_rdata)
    );

    iee_energy_acc #(
        .WEIGHT_BITS (WEIGHT_BITS),
        .ACC_W       (ACC_W)
    ) u_acc (
        .aclk   (aclk),
        .ctrl   (acc_ctrl),
        .weight ($signed(mem_rdata)),
        .energy (acc_energy)
    );

    assign m_valid     = m_valid_reg;
    assign m_energy    = m_energy_reg;
    assign m_is_energy = m_is_energy_reg;

    a_write_when_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == ST_CLEAR || state_reg == ST_IDLE))
        else $error("table written while a sweep is running");

    a_sweep_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (32'(addr_reg) < 32'(TABLE_SIZE)))
        else $error("sweep address past table end");

    a_sweep_node_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SWEEP) |-> (32'(i_reg) < 32'(NODES) &&
                                     (phase_reg || 32'(j_reg) < 32'(NODES))))
        else $error("node counter out of range during sweep");

    a_result_from_result_state: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_RESULT)
        else $error("output word loaded outside result state");

    a_ack_energy_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_is_energy_reg) |-> (m_energy_reg == '0))
        else $error("write acknowledge carries nonzero energy");

endmodule

### tb/tb_ising_energy_evaluator_unit.sv
`timescale 1ns / 1ps
// Testbench: table writes and spin evaluations checked against a local energy model.
module tb_ising_energy_evaluator_unit import iee_pkg::*;;

    localparam int NODES            = DEF_NODES;
    localparam int PAIRS            = NODES * (NODES - 1) / 2;
    localparam int TABLE_SIZE       = PAIRS + NODES;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int TAIL_CYCLES      = 160;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int MAX_REPORTS      = 10;

    typedef struct packed {
        logic signed [ENERGY_W-1:0] energy;
        logic                       is_energy;
    } result_t;

    logic                       aclk          = 1'b0;
    logic                       aresetn       = 1'b0;
    logic                       s_valid       = 1'b0;
    logic                       s_ready;
    logic                       s_cmd         = CMD_WRITE;
    logic [INDEX_W-1:0]         s_param_index = '0;
    logic signed [PARAM_W-1:0]  s_param_value = '0;
    logic [SPIN_W-1:0]          s_spin_bits   = '0;
    logic                       m_valid;
    logic                       m_ready       = 1'b0;
    logic signed [ENERGY_W-1:0] m_energy;
    logic                       m_is_energy;

    logic signed [PARAM_W-1:0] param_shadow [TABLE_SIZE];
    result_t                   pending_results [$];
    int                        mismatches     = 0;
    int                        stalled_cycles = 0;
    int                        long_hold      = 0;
    bit                        tx_idle_on     = 1'b1;
    bit                        rx_idle_on     = 1'b1;

    ising_energy_evaluator_unit uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_cmd         (s_cmd),
        .s_param_index (s_param_index),
        .s_param_value (s_param_value),
        .s_spin_bits   (s_spin_bits),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_energy      (m_energy),
        .m_is_energy   (m_is_energy)
    );

    always #5 aclk = ~aclk;

    initial begin
        for (int k = 0; k < TABLE_SIZE; k++) begin
            param_shadow[k] = '0;
        end
    end

    function automatic int spin_sign(input logic [SPIN_W-1:0] spins, input int node);
        if (node >= SPIN_W) begin
            return -1;
        end
        return spins[node] ? 1 : -1;
    endfunction

    function automatic logic signed [ENERGY_W-1:0] negated_energy(
        input logic [SPIN_W-1:0] spins);
        longint sum;
        int     slot;
        int     si;
        sum  = 0;
        slot = 0;
        for (int i = 0; i < NODES; i++) begin
            si = spin_sign(spins, i);
            for (int j = i + 1; j < NODES; j++) begin
                sum += longint'(si * spin_sign(spins, j)) * longint'(param_shadow[slot]);
                slot++;
            end
            sum += longint'(si) * longint'(param_shadow[PAIRS + i]);
        end
        sum = -sum;
        if (sum > longint'(ENERGY_MAX)) begin
            sum = longint'(ENERGY_MAX);
        end
        if (sum < longint'(ENERGY_MIN)) begin
            sum = longint'(ENERGY_MIN);
        end
        return sum[ENERGY_W-1:0];
    endfunction

    // Update the shadow table and queue the result one accepted word causes.
    function automatic void record_word(input logic cmd, input logic [INDEX_W-1:0] idx,
                                        input logic signed [PARAM_W-1:0] value,
                                        input logic [SPIN_W-1:0] spins);
        result_t res;
        if (cmd == CMD_WRITE) begin
            if (int'(idx) < TABLE_SIZE) begin
                param_shadow[idx] = value;
            end
            res.energy    = '0;
            res.is_energy = 1'b0;
        end else begin
            res.energy    = negated_energy(spins);
            res.is_energy = 1'b1;
        end
        pending_results.push_back(res);
    endfunction

    function automatic void note_mismatch(input string what);
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endfunction

    function automatic logic signed [PARAM_W-1:0] pick_value(input int mode);
        case (mode)
            0: return PARAM_W'($urandom);
            1: begin
                case ($urandom_range(0, 4))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    3: return 16'sh0001;
                    default: return 16'shFFFF;
                endcase
            end
            default: return PARAM_W'(int'($urandom_range(0, 63)) - 32);
        endcase
    endfunction

    function automatic logic [SPIN_W-1:0] pick_spins();
        logic [SPIN_W-1:0] one_hot;
        one_hot = SPIN_W'(1) << $urandom_range(0, SPIN_W - 1);
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return one_hot;
            3: return ~one_hot;
            default: return SPIN_W'($urandom);
        endcase
    endfunction

    task automatic send_word(input logic cmd, input logic [INDEX_W-1:0] idx,
                             input logic signed [PARAM_W-1:0] value,
                             input logic [SPIN_W-1:0] spins);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_param_index <= idx;
        s_param_value <= value;
        s_spin_bits   <= spins;
        do @(posedge aclk); while (s_ready !== 1'b1);
        record_word(cmd, idx, value, spins);
    endtask

    task automatic write_param(input int idx, input logic signed [PARAM_W-1:0] value);
        send_word(CMD_WRITE, idx[INDEX_W-1:0], value, SPIN_W'($urandom));
    endtask

    task automatic evaluate(input logic [SPIN_W-1:0] spins);
        send_word(CMD_EVAL, INDEX_W'($urandom), PARAM_W'($urandom), spins);
    endtask

    // Drop valid and hold off until every queued result is back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic test_cleared_table();
        evaluate(16'hFFFF);
        evaluate(16'h0000);
        evaluate(16'h1234);
    endtask

    task automatic test_directed_words();
        write_param(0, 16'sh7FFF);
        evaluate(16'hFFFF);
        evaluate(16'h0001);
        write_param(TABLE_SIZE - 1, 16'sh8000);
        evaluate(16'h8000);
        // slots past the table: acknowledge only
        write_param(TABLE_SIZE, 16'sd1234);
        write_param(255, 16'shFFFF);
        evaluate(16'hFFFF);
        write_param(PAIRS, 16'sh0001);
        write_param(PAIRS - 1, 16'shFFFF);
        write_param(127, 16'sh5A5A);
        evaluate(16'h5555);
        evaluate(16'hAAAA);
        evaluate(16'h0000);
        write_param(0, 16'sh0000);
        evaluate(16'hFFFF);
    endtask

    // Load every slot with the most negative weight to drive large full-table energies.
    task automatic test_full_scale_energy();
        for (int k = 0; k < TABLE_SIZE; k++) begin
            write_param(k, 16'sh8000);
        end
        evaluate(16'hFFFF);
        evaluate(16'h0000);
        evaluate(16'h00FF);
        evaluate(SPIN_W'($urandom));
        wait_for_results();
    endtask

    task automatic test_output_backpressure();
        tx_idle_on = 1'b0;
        wait_for_results();
        long_hold <= LONG_HOLD_CYCLES;
        repeat (8) begin
            write_param($urandom_range(0, TABLE_SIZE - 1), pick_value(0));
        end
        evaluate(pick_spins());
        evaluate(pick_spins());
        wait_for_results();
        tx_idle_on = 1'b1;
    endtask

    task automatic test_random_programs();
        int sent;
        int count;
        int vmode;
        sent = 0;
        while (sent < 250) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            rx_idle_on <= ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 5))
                3: begin
                    // noise: any command, any slot including ones past the table
                    repeat (6) begin
                        send_word(1'($urandom), INDEX_W'($urandom), PARAM_W'($urandom),
                                  SPIN_W'($urandom));
                    end
                    sent += 6;
                end
                4: begin
                    repeat (3) evaluate(pick_spins());
                    sent += 3;
                end
                default: begin
                    vmode = $urandom_range(0, 2);
                    count = $urandom_range(1, 10);
                    repeat (count) begin
                        write_param($urandom_range(0, TABLE_SIZE - 1), pick_value(vmode));
                    end
                    sent += count;
                    count = $urandom_range(1, 3);
                    repeat (count) evaluate(pick_spins());
                    sent += count;
                end
            endcase
            if ($urandom_range(0, 4) == 0) begin
                wait_for_results();
            end
        end
    endtask

    task automatic test_back_to_back();
        tx_idle_on = 1'b0;
        rx_idle_on <= 1'b0;
        repeat (12) begin
            write_param($urandom_range(0, TABLE_SIZE - 1), pick_value(0));
            evaluate(pick_spins());
        end
        wait_for_results();
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        test_cleared_table();
        test_directed_words();
        test_full_scale_energy();
        test_output_backpressure();
        test_random_programs();
        test_back_to_back();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Result side: random stall bursts, plus one long hold on request.
    initial begin
        int hold;
        @(posedge aclk);
        forever begin
            if (long_hold > 0) begin
                hold = long_hold;
                long_hold <= 0;
                m_ready <= 1'b0;
                repeat (hold) @(posedge aclk);
                m_ready <= 1'b1;
            end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
            @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                note_mismatch($sformatf("unexpected word energy=%0d is_energy=%0b",
                                        m_energy, m_is_energy));
            end else begin
                want = pending_results.pop_front();
                if (m_energy !== want.energy || m_is_energy !== want.is_energy) begin
                    note_mismatch($sformatf("energy exp %0d got %0d, is_energy exp %0b got %0b",
                                            want.energy, m_energy, want.is_energy,
                                            m_is_energy));
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stalled_cycles = 0;
        end else begin
            stalled_cycles++;
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

endmodule

### filelist.f
src/iee_pkg.sv
src/iee_param_mem.sv
src/iee_energy_acc.sv
src/ising_energy_evaluator_unit.sv
tb/tb_ising_energy_evaluator_unit.sv
